// ===== sv/angle_slew_tracker_unit_assert.svh =====
// assertion macros for the angle slew tracker
`ifndef ANGLE_SLEW_TRACKER_UNIT_ASSERT_SVH
`define ANGLE_SLEW_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define AST_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AST_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ast_pkg.sv =====
// shared types and constants for the angle slew tracker
`default_nettype none

package ast_pkg;

   localparam int ANGLE_W    = 25;
   localparam int VALUE_W    = 27;
   localparam int DELTA_W    = 16;
   localparam int MAX_RATE_W = 20;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   typedef logic [1:0] mode_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam mode_type MODE_TICK       = 2'd0;
   localparam mode_type MODE_SET_TARGET = 2'd1;
   localparam mode_type MODE_SET_ANGLE  = 2'd2;
   localparam mode_type MODE_COPY       = 2'd3;

   localparam csr_idx_type REG_MAX_RATE = 2'd0;
   localparam csr_idx_type REG_GAIN     = 2'd1;

   localparam logic [MAX_RATE_W-1:0] MAX_RATE_RESET = 20'd179200;
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = 16'd1920;

   // 360 and 180 degrees in Q16, minimum step of 0.1 degree
   localparam logic [ANGLE_W-1:0] FULL_TURN = 25'd23592960;
   localparam logic [23:0]        HALF_TURN = 24'd11796480;
   localparam logic [31:0]        MIN_STEP  = 32'd6554;

endpackage

`default_nettype wire

// ===== sv/ast_serial_mult.sv =====
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none

module ast_serial_mult #(
   parameter int PROD_W   = 56,
   parameter int MPLIER_W = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [PROD_W-1:0]   mcand,
   input  wire logic [MPLIER_W-1:0] mplier,
   output logic                     done,
   output logic [PROD_W-1:0]        product
);

   localparam int CNT_W = $clog2(MPLIER_W + 1);

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [MPLIER_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;

   always_comb begin
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      done_in   = (cnt_ff == CNT_W'(1)) && !start;
      if (start) begin
         cnt_in    = CNT_W'(MPLIER_W);
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = '0;
      end else if (cnt_ff != '0) begin
         cnt_in    = cnt_ff - CNT_W'(1);
         acc_in    = mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MPLIER_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== sv/angle_slew_tracker_unit.sv =====
// angle slew tracker: wrapped angle proportional slew-rate limiter
// tick: pass a runs in MULA, pass b in MULB, then APPLY loads the output register; set and copy go straight to APPLY
// one item at a time; a tick runs two serial multiplies
// (error times gain, then times elapsed time) on one shared shift-and-add unit
// the input is taken again while a finished result still waits at the output register
// synchronous reset: angles zero, max_rate 700.0, gain 7.5, output empty
`default_nettype none

module angle_slew_tracker_unit
   import ast_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_mode,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [DELTA_W-1:0]    req_tick_delta,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ANGLE_W-1:0]         rsp_angle,
   output logic [ANGLE_W-1:0]         rsp_target,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

`include "angle_slew_tracker_unit_assert.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MULA  = 2'd1;
   localparam logic [1:0] ST_MULB  = 2'd2;
   localparam logic [1:0] ST_APPLY = 2'd3;

   localparam int PROD_W = 56;
   localparam int CAP_W  = 36;

   logic [1:0]            state_ff, state_in;
   logic [MAX_RATE_W-1:0] max_rate_ff, max_rate_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [ANGLE_W-1:0]    cur_ff, cur_in;
   logic [ANGLE_W-1:0]    tgt_ff, tgt_in;
   mode_type              mode_ff, mode_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [DELTA_W-1:0]    dt_ff, dt_in;
   logic [23:0]           aerr_ff, aerr_in;
   logic                  err_neg_ff, err_neg_in;
   logic [27:0]           cap_ff, cap_in;
   logic [27:0]           mag_ff, mag_in;
   logic                  step_neg_ff, step_neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]    rsp_angle_ff, rsp_angle_in;
   logic [ANGLE_W-1:0]    rsp_target_ff, rsp_target_in;

   logic req_fire;
   logic rsp_free;
   logic tick_start;

   logic               mul_start;
   logic [PROD_W-1:0]  mul_mcand;
   logic [DELTA_W-1:0] mul_mplier;
   logic               mul_done;
   logic [PROD_W-1:0]  mul_prod;
   logic               cap_done;
   logic [CAP_W-1:0]   cap_prod;

   logic signed [25:0] full26, half26;
   logic signed [25:0] diff, diff_adj;
   logic [25:0]        diff_abs;
   logic               err_neg_c;

   logic [31:0] raw_mag, lo_mag;

   logic signed [26:0] full27, step27, cur27, next27, wrap27;
   logic signed [27:0] full28, v28, norm28;
   logic [ANGLE_W-1:0] norm_angle;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign tick_start = req_fire && (req_mode == MODE_TICK);

   // shortest-arc error
   always_comb begin
      full26 = $signed({1'b0, FULL_TURN});
      half26 = $signed({2'b00, HALF_TURN});
      diff   = $signed({1'b0, tgt_ff}) - $signed({1'b0, cur_ff});
      if (diff > half26) begin
         diff_adj = diff - full26;
      end else if (diff < -half26) begin
         diff_adj = diff + full26;
      end else begin
         diff_adj = diff;
      end
      err_neg_c = diff_adj[25];
      diff_abs  = err_neg_c ? 26'(-diff_adj) : 26'(diff_adj);
   end

   // pass a: error times gain, pass b: that times elapsed time
   always_comb begin
      mul_start = tick_start || ((state_ff == ST_MULA) && mul_done);
      if (state_ff == ST_IDLE) begin
         mul_mcand  = {32'd0, diff_abs[23:0]};
         mul_mplier = gain_ff;
      end else begin
         mul_mcand  = {16'd0, mul_prod[39:0]};
         mul_mplier = dt_ff;
      end
   end

   ast_serial_mult #(
      .PROD_W   (PROD_W),
      .MPLIER_W (DELTA_W)
   ) u_step_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_prod)
   );

   ast_serial_mult #(
      .PROD_W   (CAP_W),
      .MPLIER_W (DELTA_W)
   ) u_cap_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (tick_start),
      .mcand   ({16'd0, max_rate_ff}),
      .mplier  (req_tick_delta),
      .done    (cap_done),
      .product (cap_prod)
   );

   // step clamp: floor at minimum, cap applied last
   always_comb begin
      raw_mag = mul_prod[55:24];
      lo_mag  = (raw_mag < MIN_STEP) ? MIN_STEP : raw_mag;
   end

   // tick result and wrap
   always_comb begin
      full27 = $signed({2'b00, FULL_TURN});
      step27 = $signed({3'b000, mag_ff[23:0]});
      cur27  = $signed({2'b00, cur_ff});
      if (mag_ff <= {4'd0, aerr_ff}) begin
         next27 = step_neg_ff ? (cur27 - step27) : (cur27 + step27);
      end else begin
         next27 = $signed({2'b00, tgt_ff});
      end
      if (next27 >= full27) begin
         wrap27 = next27 - full27;
      end else if (next27 < 0) begin
         wrap27 = next27 + full27;
      end else begin
         wrap27 = next27;
      end
   end

   // set value normalization with saturation
   always_comb begin
      full28 = $signed({3'b000, FULL_TURN});
      v28    = $signed({value_ff[VALUE_W-1], value_ff});
      if (v28 < 0) begin
         norm28 = v28 + full28;
      end else if (v28 >= full28) begin
         norm28 = v28 - full28;
      end else begin
         norm28 = v28;
      end
      if (norm28 < 0) begin
         norm_angle = '0;
      end else if (norm28 >= full28) begin
         norm_angle = FULL_TURN - ANGLE_W'(1);
      end else begin
         norm_angle = norm28[ANGLE_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      max_rate_in   = max_rate_ff;
      gain_in       = gain_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      dt_in         = dt_ff;
      aerr_in       = aerr_ff;
      err_neg_in    = err_neg_ff;
      cap_in        = cap_ff;
      mag_in        = mag_ff;
      step_neg_in   = step_neg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_angle_in  = rsp_angle_ff;
      rsp_target_in = rsp_target_ff;

      if (csr_write_en) begin
         if (csr_index == REG_MAX_RATE) begin
            max_rate_in = csr_data[MAX_RATE_W-1:0];
         end else if (csr_index == REG_GAIN) begin
            gain_in = csr_data[GAIN_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in    = req_mode;
               value_in   = req_value;
               dt_in      = req_tick_delta;
               aerr_in    = diff_abs[23:0];
               err_neg_in = err_neg_c;
               state_in   = (req_mode == MODE_TICK) ? ST_MULA : ST_APPLY;
            end
         end
         ST_MULA: begin
            if (mul_done) begin
               state_in = ST_MULB;
            end
            if (cap_done) begin
               cap_in = cap_prod[35:8];
            end
         end
         ST_MULB: begin
            if (mul_done) begin
               step_neg_in = err_neg_ff && (raw_mag != '0);
               mag_in      = (lo_mag > {4'd0, cap_ff}) ? cap_ff : lo_mag[27:0];
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (rsp_free) begin
               unique case (mode_ff)
                  MODE_TICK:       cur_in = wrap27[ANGLE_W-1:0];
                  MODE_SET_TARGET: tgt_in = norm_angle;
                  MODE_SET_ANGLE:  cur_in = norm_angle;
                  MODE_COPY:       cur_in = tgt_ff;
                  default:         cur_in = cur_ff;
               endcase
               rsp_valid_in  = 1'b1;
               rsp_angle_in  = cur_in;
               rsp_target_in = tgt_in;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_rate_ff  <= MAX_RATE_RESET;
         gain_ff      <= GAIN_RESET;
         cur_ff       <= '0;
         tgt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_rate_ff  <= max_rate_in;
         gain_ff      <= gain_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      dt_ff         <= dt_in;
      aerr_ff       <= aerr_in;
      err_neg_ff    <= err_neg_in;
      cap_ff        <= cap_in;
      mag_ff        <= mag_in;
      step_neg_ff   <= step_neg_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_target_ff <= rsp_target_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_angle  = rsp_angle_ff;
   assign rsp_target = rsp_target_ff;

   `AST_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_fire, state_ff != ST_IDLE,
      "no work started after input transfer")
   `AST_ASSERT_SAME(a_cap_with_pass_a, clock, reset, (state_ff == ST_MULA) && mul_done,
      cap_done, "cap multiply out of step with first pass")
   `AST_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == ST_APPLY) && rsp_free,
      rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded")
   `AST_ASSERT_SAME(a_angles_in_range, clock, reset, rsp_valid_ff,
      (rsp_angle_ff < FULL_TURN) && (rsp_target_ff < FULL_TURN), "angle out of range")

endmodule

`default_nettype wire

// ===== dv/angle_slew_tracker_checker.sv =====
// checker for the angle slew tracker: tracks the angle state, predicts each result and compares
module angle_slew_tracker_checker
   import ast_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_mode,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic [DELTA_W-1:0]          req_tick_delta,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [ANGLE_W-1:0]          rsp_angle,
   input  logic [ANGLE_W-1:0]          rsp_target,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   output int                          outstanding,
   output int                          mismatches,
   output int                          checked,
   output int                          snaps
);

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [ANGLE_W-1:0] target;
   } pose_type;

   localparam longint TURN_LSB     = 64'd23592960;
   localparam longint HALF_LSB     = 64'd11796480;
   localparam longint MIN_STEP_LSB = 64'd6554;

   logic [MAX_RATE_W-1:0] rate_limit = 20'd179200;
   logic [GAIN_W-1:0]     loop_gain  = 16'd1920;
   logic [ANGLE_W-1:0]    angle_now  = '0;
   logic [ANGLE_W-1:0]    target_now = '0;
   pose_type              expected_pose_q[$];

   initial begin
      outstanding = 0;
      mismatches  = 0;
      checked     = 0;
      snaps       = 0;
   end

   task automatic report(input string what, input longint want, input longint got);
      if (mismatches < 100)
         $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
      mismatches++;
   endtask

   function automatic logic [ANGLE_W-1:0] fold_setpoint(input logic signed [VALUE_W-1:0] v);
      longint a;
      a = longint'(v);
      if (a < 0)
         a += TURN_LSB;
      else if (a >= TURN_LSB)
         a -= TURN_LSB;
      if (a < 0)
         a = 0;
      if (a >= TURN_LSB)
         a = TURN_LSB - 1;
      return a[ANGLE_W-1:0];
   endfunction

   function automatic void slew_tick(input logic [DELTA_W-1:0] dt);
      longint cur, err, aerr, mag, cap, next;
      logic   backward;
      cur = longint'(angle_now);
      err = longint'(target_now) - cur;
      // shortest arc
      if (err > HALF_LSB || err < -HALF_LSB)
         err = (err < 0) ? err + TURN_LSB : err - TURN_LSB;
      aerr = (err < 0) ? -err : err;
      mag = (aerr * longint'(loop_gain) * longint'(dt)) >> 24;
      cap = (longint'(rate_limit) * longint'(dt)) >> 8;
      // a truncated step of zero moves forward
      backward = (err < 0) && (mag != 0);
      if (mag < MIN_STEP_LSB)
         mag = MIN_STEP_LSB;
      if (mag > cap)
         mag = cap;
      if (mag <= aerr) begin
         next = backward ? cur - mag : cur + mag;
      end else begin
         next = longint'(target_now);
         snaps++;
      end
      if (next >= TURN_LSB)
         next -= TURN_LSB;
      else if (next < 0)
         next += TURN_LSB;
      angle_now = next[ANGLE_W-1:0];
   endfunction

   always @(posedge clock) begin : monitor
      pose_type want;
      if (reset) begin
         rate_limit = 20'd179200;
         loop_gain  = 16'd1920;
         angle_now  = '0;
         target_now = '0;
         expected_pose_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_MAX_RATE: rate_limit = csr_data[MAX_RATE_W-1:0];
               REG_GAIN:     loop_gain  = csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pose_q.size() == 0) begin
               report("unexpected result transfer, angle", -1, longint'(rsp_angle));
            end else begin
               want = expected_pose_q.pop_front();
               checked++;
               if (rsp_angle !== want.angle)
                  report("angle", longint'(want.angle), longint'(rsp_angle));
               if (rsp_target !== want.target)
                  report("target", longint'(want.target), longint'(rsp_target));
            end
         end
         if (req_valid && !req_stall) begin
            case (req_mode)
               MODE_TICK:       slew_tick(req_tick_delta);
               MODE_SET_TARGET: target_now = fold_setpoint(req_value);
               MODE_SET_ANGLE:  angle_now  = fold_setpoint(req_value);
               MODE_COPY:       angle_now  = target_now;
               default: ;
            endcase
            want = '{angle: angle_now, target: target_now};
            expected_pose_q.push_back(want);
         end
      end
      outstanding <= expected_pose_q.size();
   end

endmodule

// ===== dv/angle_slew_tracker_unit_tb.sv =====
// testbench top for the angle slew tracker: clock, reset, stimulus, idling and verdict
module angle_slew_tracker_unit_tb;
   import ast_pkg::*;

   localparam int ANGLE_TURN = 23592960;
   localparam int ANGLE_HALF = 11796480;
   localparam int ONE_DEG    = 65536;
   localparam logic signed [VALUE_W-1:0] VALUE_LO = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_HI = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam csr_idx_type REG_SPARE_A = 2'd2;
   localparam csr_idx_type REG_SPARE_B = 2'd3;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic [1:0]                 req_mode       = MODE_TICK;
   logic signed [VALUE_W-1:0]  req_value      = '0;
   logic [DELTA_W-1:0]         req_tick_delta = '0;
   logic                       rsp_stall      = 1'b0;
   logic                       csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index      = REG_MAX_RATE;
   logic [CSR_DATA_W-1:0]      csr_data       = '0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic [ANGLE_W-1:0]         rsp_angle;
   logic [ANGLE_W-1:0]         rsp_target;

   int outstanding, mismatches, checked, snaps;
   int items_sent     = 0;
   int settings_used  = 1;
   int stall_left     = 0;
   bit steady         = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   angle_slew_tracker_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_tick_delta (req_tick_delta),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_angle      (rsp_angle),
      .rsp_target     (rsp_target),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   angle_slew_tracker_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_tick_delta (req_tick_delta),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_angle      (rsp_angle),
      .rsp_target     (rsp_target),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .outstanding    (outstanding),
      .mismatches     (mismatches),
      .checked        (checked),
      .snaps          (snaps)
   );

   // result side: at each result transfer, draw whether and how long to stall the next result; never stall when steady
   always @(posedge clock) begin : rsp_side
      int unsigned hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold = steady ? 0 : $urandom_range(0, 3);
         stall_left <= int'(hold);
         rsp_stall  <= (hold != 0);
      end else if (rsp_valid && rsp_stall) begin
         if (stall_left <= 1)
            rsp_stall <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   task automatic push_item(input mode_type m, input logic signed [VALUE_W-1:0] v,
                            input logic [DELTA_W-1:0] dt);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_value      <= v;
      req_tick_delta <= dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // stop sending until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic retune(input logic [CSR_DATA_W-1:0] rate_word,
                         input logic [CSR_DATA_W-1:0] gain_word, input bit stray);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= REG_MAX_RATE;
      csr_data     <= rate_word;
      @(posedge clock);
      csr_index    <= REG_GAIN;
      csr_data     <= gain_word;
      @(posedge clock);
      if (stray) begin
         csr_index <= REG_SPARE_A;
         csr_data  <= CSR_DATA_W'($urandom);
         @(posedge clock);
         csr_index <= REG_SPARE_B;
         csr_data  <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return VALUE_W'($urandom_range(0, ANGLE_TURN - 1));
         6:       return VALUE_W'(-$urandom_range(1, ANGLE_TURN));
         7:       return VALUE_W'($urandom_range(ANGLE_TURN, 2 * ANGLE_TURN - 1));
         8:       return VALUE_W'($urandom);
         default: return $urandom_range(0, 1) ? VALUE_W'(ANGLE_TURN - 1) : '0;
      endcase
   endfunction

   function automatic logic [DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return DELTA_W'($urandom_range(1, 64));
         4, 5:    return DELTA_W'($urandom_range(65, 4096));
         default: return DELTA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic run_random(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) begin
         steady <= ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
               push_item(MODE_SET_TARGET, pick_value(), DELTA_W'($urandom));
               if ($urandom_range(0, 3) == 0)
                  push_item(MODE_SET_ANGLE, pick_value(), DELTA_W'($urandom));
               repeat ($urandom_range(1, 8))
                  push_item(MODE_TICK, VALUE_W'($urandom), pick_delta());
            end
            14, 15:  push_item(MODE_COPY, VALUE_W'($urandom), DELTA_W'($urandom));
            16, 17:  push_item(mode_type'($urandom_range(0, 3)), VALUE_W'($urandom),
                               DELTA_W'($urandom));
            18:      push_item(MODE_SET_ANGLE, pick_value(), DELTA_W'($urandom));
            default: drain();
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset state, zero and full elapsed time, snap onto target
      push_item(MODE_TICK, '0, '0);
      push_item(MODE_SET_TARGET, VALUE_W'(90 * ONE_DEG), '1);
      push_item(MODE_TICK, VALUE_HI, '1);
      // setpoint folding and saturation
      push_item(MODE_SET_TARGET, '1, '0);
      push_item(MODE_SET_TARGET, VALUE_LO, '1);
      push_item(MODE_SET_TARGET, VALUE_HI, '0);
      push_item(MODE_SET_TARGET, VALUE_W'(ANGLE_TURN), '0);
      push_item(MODE_SET_TARGET, VALUE_W'(2 * ANGLE_TURN - 1), '0);
      push_item(MODE_SET_TARGET, VALUE_W'(-ANGLE_TURN), '1);
      push_item(MODE_SET_ANGLE, VALUE_LO, '1);
      push_item(MODE_SET_ANGLE, VALUE_HI, '0);
      // error of exactly half a turn
      push_item(MODE_SET_ANGLE, '0, '0);
      push_item(MODE_SET_TARGET, VALUE_W'(ANGLE_HALF), '0);
      push_item(MODE_TICK, '0, 16'd100);
      // truncated step of zero with negative error moves forward
      push_item(MODE_SET_TARGET, '0, '0);
      push_item(MODE_SET_ANGLE, VALUE_W'(8000), '0);
      push_item(MODE_TICK, '0, 16'd1);
      // cap below the minimum step
      push_item(MODE_TICK, '0, 16'd5);
      // wrap over 360 and under 0
      push_item(MODE_SET_ANGLE, VALUE_W'(ANGLE_TURN - ONE_DEG), '0);
      push_item(MODE_SET_TARGET, VALUE_W'(ONE_DEG), '0);
      push_item(MODE_TICK, '0, 16'd5000);
      push_item(MODE_SET_ANGLE, VALUE_W'(ONE_DEG), '0);
      push_item(MODE_SET_TARGET, VALUE_W'(ANGLE_TURN - ONE_DEG), '0);
      push_item(MODE_TICK, '1, 16'd5000);
      push_item(MODE_COPY, VALUE_HI, '1);

      run_random(170);
      for (int phase = 1; phase < 8; phase++) begin
         case (phase)
            1:       retune('1, 20'h0FFFF, 1'b0);
            2:       retune('0, 20'h0FFFF, 1'b0);
            3:       retune('1, '0, 1'b0);
            4:       retune(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), 1'b1);
            5:       retune(CSR_DATA_W'($urandom_range(0, 20'hFFFFF)),
                            CSR_DATA_W'($urandom_range(0, 2048)), 1'b0);
            6:       retune(20'd179200, 20'd1920, 1'b0);
            default: retune(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(0, 1024)),
                            1'b1);
         endcase
         run_random(150);
      end

      steady <= 1'b0;
      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d transfers over %0d register settings", items_sent, settings_used);
      $display("%0d results checked, %0d ticks snapped onto target", checked, snaps);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
